[src/bavg_pkg.sv]
// Shared widths, defaults and operation codes for the binned averaging shift register.
package bavg_pkg;

  localparam int unsigned NumBinsDef   = 8;
  localparam int unsigned SampleWDef   = 32;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned LagW         = 12;
  localparam int unsigned CntW         = 13;
  localparam int unsigned FillW        = 4;
  localparam int unsigned BinW         = 3;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned FuncW        = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_SET   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Reset value of partition register k: 2^k - 1
  function automatic logic [LagW-1:0] lag_reset(input int unsigned k);
    logic [LagW-1:0] v;
    v = '0;
    for (int unsigned i = 0; i < NumRegs; i++) begin
      if (i < k) v[i] = 1'b1;
    end
    return v;
  endfunction

endpackage

[src/bavg_cell.sv]
// One bin: running average and fill count, with a bit-serial divider for the update.
module bavg_cell import bavg_pkg::*; #(
  parameter int unsigned SampleW = SampleWDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      set_i,
  input  logic signed [SampleW-1:0] set_val_i,
  input  logic                      start_i,
  input  logic                      inc_i,
  input  logic signed [SampleW-1:0] src_i,
  output logic signed [SampleW-1:0] avg_o,
  output logic [CntW-1:0]           cnt_o,
  output logic                      busy_o
);

  localparam int unsigned StepW = $clog2(SampleW + 2);
  localparam logic [StepW-1:0] Steps = StepW'(SampleW + 1);

  logic signed [SampleW-1:0] avg_q;
  logic [CntW-1:0]           cnt_q, div_q, cnt_new;
  logic [SampleW:0]          quo_q, diff, mag;
  logic [CntW:0]             rem_q, rem_sh, rem_sub;
  logic                      neg_q, busy_q;
  logic [StepW-1:0]          step_q;
  logic [SampleW:0]          sum;

  // Difference to the source, magnitude and count for the divider
  always_comb begin
    cnt_new = inc_i ? cnt_q + CntW'(1) : cnt_q;
    diff    = {src_i[SampleW-1], src_i} - {avg_q[SampleW-1], avg_q};
    mag     = diff[SampleW] ? -diff : diff;
    rem_sh  = {rem_q[CntW-1:0], quo_q[SampleW]};
    rem_sub = rem_sh - {1'b0, div_q};
    sum     = neg_q ? ({avg_q[SampleW-1], avg_q} - quo_q)
                    : ({avg_q[SampleW-1], avg_q} + quo_q);
  end

  // Hold bin state; one quotient bit per cycle, then add to the average
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      step_q <= '0;
      div_q  <= CntW'(1);
      quo_q  <= '0;
      rem_q  <= '0;
      neg_q  <= 1'b0;
    end else if (clear_i) begin
      avg_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (set_i) begin
      avg_q <= set_val_i;
    end else if (start_i) begin
      cnt_q  <= cnt_new;
      div_q  <= (cnt_new == '0) ? CntW'(1) : cnt_new;
      neg_q  <= diff[SampleW];
      quo_q  <= mag;
      rem_q  <= '0;
      step_q <= Steps;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (step_q != '0) begin
        step_q <= step_q - StepW'(1);
        if (!rem_sub[CntW]) begin
          rem_q <= rem_sub;
          quo_q <= {quo_q[SampleW-1:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[SampleW-1:0], 1'b0};
        end
      end else begin
        avg_q  <= sum[SampleW-1:0];
        busy_q <= 1'b0;
      end
    end
  end

  assign avg_o  = avg_q;
  assign cnt_o  = cnt_q;
  assign busy_o = busy_q;

endmodule

[src/binned_averaging_shift_register_core.sv]
// Top level: partition registers, fill pointer, chain of bin cells and result sequencer.
// A push runs the divider (one quotient bit per cycle in every active cell, all in
// parallel), then NUM_BINS results go out, one per cycle when taken.
// Clear, set and the unused code go straight to the results. One request at a time.
// Reset (asynchronous, active low) zeroes all bins and the fill pointer and restores
// the partition registers to 0, 1, 3, 7, 15, 31, 63, 127.
module binned_averaging_shift_register_core import bavg_pkg::*; #(
  parameter int unsigned NUM_BINS     = NumBinsDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWDef,
  localparam int unsigned InW  = ((2 * SAMPLE_WIDTH + BinW + 7) / 8) * 8,
  localparam int unsigned OutW = ((SAMPLE_WIDTH + BinW + CntW + FillW + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // sample, bin_index, set_value (from bit 0 up)
  input  logic [InW-1:0]     s_axis_tdata,
  // func
  input  logic [FuncW-1:0]   s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // bin_number, bin_average, bin_count, fill_index (from bit 0 up)
  output logic [OutW-1:0]    m_axis_tdata,
  output logic               m_axis_tlast,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [LagW-1:0]    cfg_data_i
);

  localparam int unsigned SW = SAMPLE_WIDTH;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_e;

  state_e                state_q;
  logic [BinW-1:0]       idx_q;
  logic [FillW-1:0]      fill_q;
  logic [LagW-1:0]       lag_q [NumRegs];
  logic [CntW-1:0]       size   [NUM_BINS];
  logic signed [SW-1:0]  avg    [NUM_BINS];
  logic [CntW-1:0]       cnt    [NUM_BINS];
  logic [NUM_BINS-1:0]   busy;
  logic [CntW-1:0]       fill_cnt_next;
  logic                  accept, do_push, do_clear, do_set, all_full, fill_adv;
  func_e                 func;
  logic signed [SW-1:0]  sample, set_value;
  logic [BinW-1:0]       bin_index;

  assign func      = func_e'(s_axis_tuser);
  assign sample    = s_axis_tdata[SW-1:0];
  assign bin_index = s_axis_tdata[SW+BinW-1:SW];
  assign set_value = s_axis_tdata[2*SW+BinW-1:SW+BinW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign do_push  = accept && (func == FUNC_PUSH);
  assign do_clear = (accept && (func == FUNC_CLEAR)) || cfg_we_i;
  assign do_set   = accept && (func == FUNC_SET);
  assign all_full = (fill_q == FillW'(NUM_BINS));

  // Bin sizes from the partition; non-increasing gives one
  always_comb begin
    for (int k = 0; k < NUM_BINS; k++) begin
      if (k == 0) size[k] = {1'b0, lag_q[0]} + CntW'(1);
      else size[k] = (lag_q[k] > lag_q[k-1]) ? CntW'(lag_q[k] - lag_q[k-1]) : CntW'(1);
    end
  end

  // Advance the fill pointer when the filling bin reaches its size
  always_comb begin
    fill_cnt_next = '0;
    fill_adv      = 1'b0;
    for (int k = 0; k < NUM_BINS; k++) begin
      if (fill_q == FillW'(k)) begin
        fill_cnt_next = cnt[k] + CntW'(1);
        fill_adv      = (fill_cnt_next >= size[k]);
      end
    end
  end

  // Chain of cells: each takes its lower neighbor's average, bin 0 the sample
  for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
    logic signed [SW-1:0] src;
    if (k == 0) begin : g_first
      assign src = sample;
    end else begin : g_next
      assign src = avg[k-1];
    end
    bavg_cell #(.SampleW(SW)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (do_clear),
      .set_i     (do_set && (bin_index == BinW'(k))),
      .set_val_i (set_value),
      .start_i   (do_push && (all_full || (fill_q >= FillW'(k)))),
      .inc_i     (fill_q == FillW'(k)),
      .src_i     (src),
      .avg_o     (avg[k]),
      .cnt_o     (cnt[k]),
      .busy_o    (busy[k])
    );
  end

  // Hold partition registers, fill pointer and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      fill_q  <= '0;
      for (int i = 0; i < NumRegs; i++) lag_q[i] <= lag_reset(i);
    end else begin
      if (cfg_we_i) lag_q[cfg_idx_i] <= cfg_data_i;
      if (do_clear) fill_q <= '0;
      else if (do_push && !all_full && fill_adv) fill_q <= fill_q + FillW'(1);
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (accept) state_q <= (func == FUNC_PUSH) ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (busy == '0) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (idx_q == BinW'(NUM_BINS - 1)) state_q <= ST_IDLE;
            else idx_q <= idx_q + BinW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Select the reported bin
  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < NUM_BINS; k++) begin
      if (idx_q == BinW'(k)) begin
        m_axis_tdata[BinW+SW-1:BinW]                     = avg[k];
        m_axis_tdata[BinW+SW+CntW-1:BinW+SW]             = cnt[k];
      end
    end
    m_axis_tdata[BinW-1:0]                               = idx_q;
    m_axis_tdata[BinW+SW+CntW+FillW-1:BinW+SW+CntW]      = fill_q;
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tlast  = (idx_q == BinW'(NUM_BINS - 1));

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(NUM_BINS)) else $error("fill pointer beyond bin count");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken while results pending");
  a_busy_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy != '0) |-> (state_q == ST_DIV)) else $error("cell busy outside divide");
  a_out_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (idx_q == '0)) else $error("results start past bin 0");
`endif

endmodule
